// ===== design/sfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, codes and the crc-8 byte update for the status frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] HDR0     = 8'h55;
  localparam logic [7:0] HDR1     = 8'hAA;
  localparam logic [7:0] TAIL_CR  = 8'h0D;
  localparam logic [7:0] TAIL_LF  = 8'h0A;
  localparam logic [15:0] CMD_RESET = 16'hA55A;

  localparam int OUT_W = 112;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HDR_ERR = 3'd1;
  localparam logic [2:0] ST_CMD_ERR = 3'd2;
  localparam logic [2:0] ST_TAIL_ERR = 3'd3;
  localparam logic [2:0] ST_CRC_ERR = 3'd4;

  typedef enum logic {
    MODE_FRAME = 1'b0,
    MODE_SKIP  = 1'b1
  } mode_e;

  typedef struct packed {
    logic [7:0]  payload_length;
    logic [31:0] angle_word;
    logic [31:0] right_word;
    logic [31:0] left_word;
    logic [2:0]  frame_status;
  } result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/sfp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_parser
// Frame state, crc accumulation, payload capture and status decision per byte.
// ----------------------------------------------------------------------------
module sfp_parser #(
  parameter int MaxFrameBytes = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic [15:0]     expected_cmd_i,
  output logic            res_valid_o,
  output sfp_pkg::result_t res_o
);

  localparam int POS_W = $clog2(MaxFrameBytes);
  localparam logic [9:0] MAX_LEN = 10'(MaxFrameBytes - 8);

  sfp_pkg::mode_e mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic last_cr_q, last_cr_d;
  logic [7:0] crc_q, crc_d;
  logic [15:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [31:0] left_q, left_d, right_q, right_d, angle_q, angle_d;
  logic [7:0] rx_crc_q, rx_crc_d;
  logic tail_bad_q, tail_bad_d;

  logic [9:0] p10;
  logic [9:0] l10;
  logic [3:0] off;
  logic tail_now;
  logic [2:0] status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sfp_pkg::MODE_FRAME;
      pos_q     <= '0;
      last_cr_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      last_cr_q <= last_cr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q      <= crc_d;
    cmd_q      <= cmd_d;
    len_q      <= len_d;
    left_q     <= left_d;
    right_q    <= right_d;
    angle_q    <= angle_d;
    rx_crc_q   <= rx_crc_d;
    tail_bad_q <= tail_bad_d;
  end

  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    last_cr_d   = last_cr_q;
    crc_d       = crc_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    left_d      = left_q;
    right_d     = right_q;
    angle_d     = angle_q;
    rx_crc_d    = rx_crc_q;
    tail_bad_d  = tail_bad_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    p10         = {{(10-POS_W){1'b0}}, pos_q};
    l10         = {2'b00, len_q};
    off         = 4'(p10 - 10'd5);
    tail_now    = 1'b0;
    status      = sfp_pkg::ST_OK;

    if (accept_i) begin
      case (mode_q)
        sfp_pkg::MODE_SKIP: begin
          if (last_cr_q && byte_i == sfp_pkg::TAIL_LF) begin
            mode_d    = sfp_pkg::MODE_FRAME;
            pos_d     = '0;
            last_cr_d = 1'b0;
          end else begin
            last_cr_d = (byte_i == sfp_pkg::TAIL_CR);
          end
        end
        default: begin
          if (p10 == 10'd0) begin
            crc_d      = '0;
            cmd_d      = '0;
            len_d      = '0;
            left_d     = '0;
            right_d    = '0;
            angle_d    = '0;
            rx_crc_d   = '0;
            tail_bad_d = 1'b0;
            if (byte_i != sfp_pkg::HDR0) begin
              res_valid_o        = 1'b1;
              res_o.frame_status = sfp_pkg::ST_HDR_ERR;
              mode_d             = sfp_pkg::MODE_SKIP;
              pos_d              = '0;
              last_cr_d          = (byte_i == sfp_pkg::TAIL_CR);
            end else begin
              crc_d = sfp_pkg::crc8_update(8'h00, byte_i);
              pos_d = POS_W'(1);
            end
          end else if (p10 == 10'd1) begin
            if (byte_i != sfp_pkg::HDR1) begin
              res_valid_o        = 1'b1;
              res_o.frame_status = sfp_pkg::ST_HDR_ERR;
              mode_d             = sfp_pkg::MODE_SKIP;
              pos_d              = '0;
              last_cr_d          = (byte_i == sfp_pkg::TAIL_CR);
            end else begin
              crc_d = sfp_pkg::crc8_update(crc_q, byte_i);
              pos_d = POS_W'(2);
            end
          end else if (p10 == 10'd2 || p10 == 10'd3) begin
            if (p10 == 10'd2) begin
              cmd_d[7:0] = byte_i;
            end else begin
              cmd_d[15:8] = byte_i;
            end
            crc_d = sfp_pkg::crc8_update(crc_q, byte_i);
            pos_d = pos_q + POS_W'(1);
          end else if (p10 == 10'd4) begin
            len_d = byte_i;
            crc_d = sfp_pkg::crc8_update(crc_q, byte_i);
            if ({2'b00, byte_i} > MAX_LEN) begin
              res_valid_o          = 1'b1;
              res_o.frame_status   = (cmd_q != expected_cmd_i) ? sfp_pkg::ST_CMD_ERR
                                                               : sfp_pkg::ST_TAIL_ERR;
              res_o.payload_length = byte_i;
              mode_d               = sfp_pkg::MODE_SKIP;
              pos_d                = '0;
              last_cr_d            = (byte_i == sfp_pkg::TAIL_CR);
            end else begin
              pos_d = POS_W'(5);
            end
          end else begin
            // payload capture window, positions five to sixteen
            if (p10 <= 10'd16) begin
              case (off[3:2])
                2'd0:    left_d[off[1:0]*8 +: 8] = byte_i;
                2'd1:    right_d[off[1:0]*8 +: 8] = byte_i;
                default: angle_d[off[1:0]*8 +: 8] = byte_i;
              endcase
            end
            if (p10 < l10 + 10'd5) begin
              crc_d = sfp_pkg::crc8_update(crc_q, byte_i);
              pos_d = pos_q + POS_W'(1);
            end else if (p10 == l10 + 10'd5) begin
              rx_crc_d = byte_i;
              pos_d    = pos_q + POS_W'(1);
            end else if (p10 == l10 + 10'd6) begin
              if (byte_i != sfp_pkg::TAIL_CR) begin
                tail_bad_d = 1'b1;
              end
              pos_d = pos_q + POS_W'(1);
            end else begin
              tail_now = tail_bad_q | (byte_i != sfp_pkg::TAIL_LF);
              tail_bad_d = tail_now;
              if (cmd_q != expected_cmd_i) begin
                status = sfp_pkg::ST_CMD_ERR;
              end else if (tail_now) begin
                status = sfp_pkg::ST_TAIL_ERR;
              end else if (crc_q != rx_crc_q) begin
                status = sfp_pkg::ST_CRC_ERR;
              end else begin
                status = sfp_pkg::ST_OK;
              end
              res_valid_o          = 1'b1;
              res_o.frame_status   = status;
              res_o.payload_length = len_q;
              if (status == sfp_pkg::ST_OK) begin
                res_o.left_word  = left_d;
                res_o.right_word = right_d;
                res_o.angle_word = angle_d;
              end
              pos_d = '0;
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== design/sfp_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_out_reg
// Result register between the parser and the output stream.
// ----------------------------------------------------------------------------
module sfp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  input  sfp_pkg::result_t load_data_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sfp_pkg::result_t out_data_o
);

  logic             valid_q;
  sfp_pkg::result_t data_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_valid_i) begin
      data_q <= load_data_i;
    end
  end

endmodule

// ===== design/status_frame_parser_crc8_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_frame_parser_crc8_core
// Parses 55 AA framed status messages with crc-8 check from a byte stream.
// ----------------------------------------------------------------------------
// usage
//   slave stream: one received byte per item in s_axis_tdata
//   master stream: one status item per finished or rejected frame
//   cfg_we_i / cfg_wdata_i: expected command word, write only while idle
// throughput: one byte per cycle while the result register is free; the crc
//   update, position compare and capture for a byte sit between the parser state and the result register
// result: registered, it shows on the master side in the cycle after the byte
//   that ends the frame (final LF, bad header byte or oversized length)
// reset: parser waits for a frame start, command register holds 0xA55A,
//   no result pending
// stall: while a result waits and the receiver holds tready low, the
//   slave tready is low too; the waiting result is held unchanged
// frames longer than MAX_FRAME_BYTES are rejected as the length byte arrives
// ----------------------------------------------------------------------------
module status_frame_parser_crc8_core #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_byte[7:0]
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_status[2:0], left_word[34:3], right_word[66:35],
  // angle_word[98:67], payload_length[106:99], zero fill
  output logic [sfp_pkg::OUT_W-1:0] m_axis_tdata
);

  logic [15:0]      exp_cmd_q;
  logic             accept;
  logic             res_valid;
  sfp_pkg::result_t res;
  sfp_pkg::result_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_cmd_q <= sfp_pkg::CMD_RESET;
    end else if (cfg_we_i) begin
      exp_cmd_q <= cfg_wdata_i;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  sfp_parser #(
    .MaxFrameBytes(MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .byte_i        (s_axis_tdata),
    .expected_cmd_i(exp_cmd_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  sfp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_valid_i(res_valid),
    .load_data_i (res),
    .free_o      (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {{(sfp_pkg::OUT_W - $bits(sfp_pkg::result_t)){1'b0}}, out_res};

`ifndef ASSERT_OFF
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_res.frame_status <= sfp_pkg::ST_CRC_ERR)
    else $error("status code out of range");

  a_err_no_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.frame_status != sfp_pkg::ST_OK |->
      out_res.left_word == '0 && out_res.right_word == '0 && out_res.angle_word == '0)
    else $error("payload words on failed frame");

  a_hdr_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.frame_status == sfp_pkg::ST_HDR_ERR |->
      out_res.payload_length == '0)
    else $error("length reported on header error");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams of status frames into status_frame_parser_crc8_core.
// A scoreboard parses the same bytes on its own, with crc-8, header, length
// and tail handling, and compares every status item field by field. Directed
// frames come first, then random frames, noise and broken headers under
// several command settings, with random gaps and receiver stalls in all but the last phase.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAME_LIMIT = 256;
  localparam int FAULT_CRC   = 1;
  localparam int FAULT_CR    = 2;
  localparam int FAULT_LF    = 4;
  localparam int FILL_RANDOM = -1;
  localparam int PHASE_BYTES = 160;

  class frame_scoreboard;
    int                      frame_limit;
    logic [15:0]             cmd_setting;
    sfp_pkg::mode_e          mode;
    logic [8:0]              pos;
    logic [7:0]              crc;
    logic [15:0]             cmd;
    logic [7:0]              len;
    logic [31:0]             left_w;
    logic [31:0]             right_w;
    logic [31:0]             angle_w;
    logic [7:0]              rx_crc;
    bit                      tail_bad;
    bit                      saw_cr;
    sfp_pkg::result_t        pending[$];
    int                      errors;

    function new(int limit);
      frame_limit = limit;
      cmd_setting = sfp_pkg::CMD_RESET;
      mode = sfp_pkg::MODE_FRAME;
      pos = '0;
      crc = '0;
      cmd = '0;
      len = '0;
      left_w = '0;
      right_w = '0;
      angle_w = '0;
      rx_crc = '0;
      tail_bad = 1'b0;
      saw_cr = 1'b0;
      errors = 0;
    endfunction

    static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c = c >> 1;
        if (fb) c = c ^ sfp_pkg::CRC_POLY;
      end
      return c;
    endfunction

    function void post(logic [2:0] status, bit with_words, logic [7:0] length);
      sfp_pkg::result_t r;
      r.frame_status = status;
      r.left_word = with_words ? left_w : '0;
      r.right_word = with_words ? right_w : '0;
      r.angle_word = with_words ? angle_w : '0;
      r.payload_length = length;
      pending.push_back(r);
    endfunction

    function void start_skip(logic [7:0] b);
      mode = sfp_pkg::MODE_SKIP;
      pos = '0;
      saw_cr = (b == sfp_pkg::TAIL_CR);
    endfunction

    function void note_byte(logic [7:0] b);
      int p;
      int l;
      logic [1:0] lane;
      logic [2:0] status;
      p = pos;
      l = len;
      if (mode == sfp_pkg::MODE_SKIP) begin
        if (saw_cr && b == sfp_pkg::TAIL_LF) begin
          mode = sfp_pkg::MODE_FRAME;
          pos = '0;
          saw_cr = 1'b0;
        end else begin
          saw_cr = (b == sfp_pkg::TAIL_CR);
        end
        return;
      end
      if (p == 0) begin
        crc = '0;
        cmd = '0;
        len = '0;
        left_w = '0;
        right_w = '0;
        angle_w = '0;
        rx_crc = '0;
        tail_bad = 1'b0;
        if (b != sfp_pkg::HDR0) begin
          post(sfp_pkg::ST_HDR_ERR, 1'b0, 8'd0);
          start_skip(b);
          return;
        end
        crc = crc_step(8'd0, b);
        pos = 9'd1;
        return;
      end
      if (p == 1) begin
        if (b != sfp_pkg::HDR1) begin
          post(sfp_pkg::ST_HDR_ERR, 1'b0, 8'd0);
          start_skip(b);
          return;
        end
        crc = crc_step(crc, b);
        pos = 9'd2;
        return;
      end
      if (p < 4) begin
        if (p == 2) cmd[7:0] = b;
        else cmd[15:8] = b;
        crc = crc_step(crc, b);
        pos = pos + 9'd1;
        return;
      end
      if (p == 4) begin
        len = b;
        crc = crc_step(crc, b);
        if (8 + int'(b) > frame_limit) begin
          post((cmd != cmd_setting) ? sfp_pkg::ST_CMD_ERR : sfp_pkg::ST_TAIL_ERR, 1'b0, b);
          start_skip(b);
          return;
        end
        pos = 9'd5;
        return;
      end
      // payload offsets 0..11 land in the three words, whatever byte sits there
      if (p <= 16) begin
        lane = 2'(p - 5);
        case ((p - 5) >> 2)
          0: left_w[8*lane +: 8] = b;
          1: right_w[8*lane +: 8] = b;
          default: angle_w[8*lane +: 8] = b;
        endcase
      end
      if (p < 5 + l) begin
        crc = crc_step(crc, b);
        pos = pos + 9'd1;
        return;
      end
      if (p == 5 + l) begin
        rx_crc = b;
        pos = pos + 9'd1;
        return;
      end
      if (p == 6 + l) begin
        if (b != sfp_pkg::TAIL_CR) tail_bad = 1'b1;
        pos = pos + 9'd1;
        return;
      end
      if (b != sfp_pkg::TAIL_LF) tail_bad = 1'b1;
      if (cmd != cmd_setting) status = sfp_pkg::ST_CMD_ERR;
      else if (tail_bad) status = sfp_pkg::ST_TAIL_ERR;
      else if (crc != rx_crc) status = sfp_pkg::ST_CRC_ERR;
      else status = sfp_pkg::ST_OK;
      post(status, status == sfp_pkg::ST_OK, len);
      pos = '0;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [sfp_pkg::OUT_W-1:0] data);
      sfp_pkg::result_t got;
      sfp_pkg::result_t want;
      got = sfp_pkg::result_t'(data[$bits(sfp_pkg::result_t)-1:0]);
      if (pending.size() == 0) begin
        $display("%0t: unexpected status item, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
      compare_field("left_word", want.left_word, got.left_word);
      compare_field("right_word", want.right_word, got.right_word);
      compare_field("angle_word", want.angle_word, got.angle_word);
      compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [15:0]                 cfg_wdata_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [sfp_pkg::OUT_W-1:0]   m_axis_tdata;

  frame_scoreboard sb = new(FRAME_LIMIT);
  bit no_idle = 1'b0;
  int bytes_sent = 0;

  status_frame_parser_crc8_core #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver with random stall bursts
  initial begin
    int hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [15:0] cmd_word, input logic [7:0] length,
                            input int faults, input int fill);
    logic [7:0] bytes[$];
    logic [7:0] crc;
    bytes = {sfp_pkg::HDR0, sfp_pkg::HDR1, cmd_word[7:0], cmd_word[15:8], length};
    if (8 + int'(length) > FRAME_LIMIT) begin
      // rejected at the length byte, so just resync with cr lf
      bytes.push_back(sfp_pkg::TAIL_CR);
      bytes.push_back(sfp_pkg::TAIL_LF);
    end else begin
      for (int i = 0; i < int'(length); i++)
        bytes.push_back((fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill));
      crc = 8'd0;
      foreach (bytes[i]) crc = frame_scoreboard::crc_step(crc, bytes[i]);
      if (faults & FAULT_CRC) crc = crc ^ 8'($urandom_range(1, 255));
      bytes.push_back(crc);
      bytes.push_back((faults & FAULT_CR) ?
                      (sfp_pkg::TAIL_CR ^ 8'($urandom_range(1, 255))) : sfp_pkg::TAIL_CR);
      bytes.push_back((faults & FAULT_LF) ?
                      (sfp_pkg::TAIL_LF ^ 8'($urandom_range(1, 255))) : sfp_pkg::TAIL_LF);
    end
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic settle_and_write(input logic [15:0] value);
    while (sb.mode != sfp_pkg::MODE_FRAME || sb.pos != 0)
      send_byte((sb.mode == sfp_pkg::MODE_SKIP && !sb.saw_cr) ? sfp_pkg::TAIL_CR
                                                                : sfp_pkg::TAIL_LF);
    go_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cmd_setting = value;
  endtask

  task automatic random_chunk();
    int r;
    int n;
    logic [15:0] cmd_word;
    logic [7:0] length;
    int faults;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom));
    end else if (r < 12) begin
      send_byte(sfp_pkg::HDR0);
      send_byte(sfp_pkg::HDR1 ^ 8'($urandom_range(1, 255)));
    end else if (r < 15) begin
      send_byte(sfp_pkg::TAIL_CR);
      send_byte(sfp_pkg::TAIL_LF);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 80) cmd_word = sb.cmd_setting;
      else if (r < 90) cmd_word = sb.cmd_setting ^ (16'd1 << $urandom_range(0, 15));
      else cmd_word = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 2) length = 8'($urandom_range(FRAME_LIMIT - 7, 255));
      else if (r < 3) length = 8'($urandom_range(100, FRAME_LIMIT - 8));
      else length = 8'($urandom_range(0, 20));
      r = $urandom_range(0, 9);
      if (r == 0) faults = FAULT_CRC;
      else if (r == 1) faults = FAULT_CR;
      else if (r == 2) faults = FAULT_LF;
      else if (r == 3) faults = $urandom_range(1, 7);
      else faults = 0;
      send_frame(cmd_word, length, faults, FILL_RANDOM);
    end
  endtask

  task automatic run_phase(input logic [15:0] value, input bit quiet);
    int target;
    settle_and_write(value);
    no_idle = quiet;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) random_chunk();
  endtask

  task automatic directed_frames();
    send_frame(sfp_pkg::CMD_RESET, 8'd12, 0, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'd0, 0, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'd5, 0, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'd13, 0, 8'hFF);
    send_frame(sfp_pkg::CMD_RESET, 8'd14, 0, 8'h00);
    // bad first header byte, skip to cr lf
    send_byte(8'h00);
    send_byte(8'h42);
    send_byte(sfp_pkg::TAIL_CR);
    send_byte(sfp_pkg::TAIL_LF);
    // a bad header byte that is itself a cr
    send_byte(sfp_pkg::TAIL_CR);
    send_byte(sfp_pkg::TAIL_LF);
    send_byte(sfp_pkg::HDR0);
    send_byte(sfp_pkg::TAIL_CR);
    send_byte(sfp_pkg::TAIL_LF);
    send_byte(8'hFF);
    send_byte(sfp_pkg::TAIL_CR);
    send_byte(sfp_pkg::TAIL_CR);
    send_byte(sfp_pkg::TAIL_LF);
    send_frame(sfp_pkg::CMD_RESET ^ 16'h0001, 8'd3, 0, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET ^ 16'h8000, 8'd12, FAULT_CRC | FAULT_CR | FAULT_LF,
               FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'd4, FAULT_CR, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'd12, FAULT_LF, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'd7, FAULT_CRC | FAULT_LF, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'd12, FAULT_CRC, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'(FRAME_LIMIT - 7), 0, FILL_RANDOM);
    send_frame(16'h0000, 8'd255, 0, FILL_RANDOM);
    send_frame(sfp_pkg::CMD_RESET, 8'(FRAME_LIMIT - 8), 0, FILL_RANDOM);
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_frames();
    run_phase(16'hFFFF, 1'b0);
    run_phase(16'h0000, 1'b0);
    run_phase(16'($urandom), 1'b0);
    run_phase(sfp_pkg::CMD_RESET, 1'b1);
    go_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
